@@ rtl/pfds_pkg.sv @@
// pfds_pkg: shared types, codes and constants for the pwm frequency divider search
// depends on nothing; used by pwm_freq_divider_search and pwm_freq_divider_search_tb
package pfds_pkg;

    localparam int REF_CLOCK_KHZ_DEF = 27000;
    localparam int KHZ_TO_HZ         = 1000;
    localparam int FREQ_W            = 20;
    localparam int PN_W              = 5;
    localparam int F_W               = 8;
    localparam int STS_W             = 2;
    localparam int F_MAX             = 255;
    // wide enough for 255 << 31
    localparam int SHIFT_SPAN_W      = F_W + (1 << PN_W);

    typedef enum logic [STS_W-1:0] {
        STS_OK        = 2'd0,
        STS_FREQ_ZERO = 2'd1,
        STS_RANGE     = 2'd2,
        STS_NO_FIT    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_WIN,
        ST_CHK,
        ST_SRCH,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [FREQ_W-1:0] desired_freq_hz;
        logic [PN_W-1:0]   bit_count_min;
        logic [PN_W-1:0]   bit_count_max;
    } t_req;

    typedef struct packed {
        logic [STS_W-1:0]  status;
        logic [PN_W-1:0]   bit_count;
        logic [F_W-1:0]    pre_divider;
    } t_rsp;

endpackage

@@ rtl/pfds_div.sv @@
// pfds_div: restoring divider, one quotient bit per cycle
// depends on nothing outside this file
module pfds_div #(
    parameter int DVD_W = 28,
    parameter int DSR_W = 20
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DSR_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DSR_W:0]   r_rem;
    logic [DVD_W-1:0] r_quo;
    logic [DSR_W-1:0] r_dsr;

    logic [DSR_W:0]   trial;
    logic             fits;
    logic [DSR_W:0]   n_rem;
    logic             last;

    // shift in next dividend bit, subtract when it fits
    always_comb begin
        trial = {r_rem[DSR_W-1:0], r_quo[DVD_W-1]};
        fits  = trial >= {1'b0, r_dsr};
        n_rem = fits ? (trial - {1'b0, r_dsr}) : trial;
        last  = r_busy && (r_cnt == CNT_W'(DVD_W - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DVD_W-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= last;
        end
    end

    assign o_quot = r_quo;

endmodule

@@ rtl/pwm_freq_divider_search.sv @@
// pwm_freq_divider_search: backlight pwm pre-divider and bit count search
// depends on pfds_pkg and pfds_div
//
// usage:
//   request channel: i_in_valid / o_in_stall / i_in_req (frequency, min and max bit count)
//   response channel: o_out_valid / i_out_stall / o_out_rsp (status, bit count, pre-divider)
//   a request is taken only while the block is idle; o_in_stall stays high until the
//   search is done and its response has moved into the output register
//   steps, from taking the request to loading the output register: a zero frequency
//   goes straight to the output register; otherwise DVD_W divider steps (25 at the
//   default 27000 khz clock, one quotient bit each), the done flag, the window, the
//   range check, one search step per bit count tried (at most 32) and the load of
//   the output register; a request out of range skips the search steps
//   the shared shift / compare step of the search sets the per-bit-count cost
//   the next request can be taken once the block is back in idle, even while the
//   previous response still waits in the output register
//   if the receiver stalls, a finished search holds until the register frees up
//   reset (synchronous, active low) returns to idle and drops o_out_valid
module pwm_freq_divider_search #(
    parameter int REF_CLOCK_KHZ = pfds_pkg::REF_CLOCK_KHZ_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  pfds_pkg::t_req i_in_req,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output pfds_pkg::t_rsp o_out_rsp
);

    localparam int NUM   = REF_CLOCK_KHZ * pfds_pkg::KHZ_TO_HZ;
    localparam int DVD_W = $clog2(NUM + (1 << (pfds_pkg::FREQ_W - 1)) + 1);
    localparam int FXP_W = $clog2(NUM + 1);
    localparam int CW    = (FXP_W + 3 > pfds_pkg::SHIFT_SPAN_W) ?
                           (FXP_W + 3) : pfds_pkg::SHIFT_SPAN_W;

    pfds_pkg::t_state r_state, n_state;
    pfds_pkg::t_req   r_req;
    pfds_pkg::t_rsp   r_res, n_res;
    pfds_pkg::t_rsp   r_rsp;
    logic             r_ovld;
    logic [FXP_W-1:0] r_fxp;
    logic [CW-1:0]    r_lo, r_hi;
    logic [pfds_pkg::PN_W-1:0] r_pn, n_pn;

    logic             in_acc;
    logic             freq_zero;
    logic             div_start;
    logic             div_done;
    logic [DVD_W-1:0] div_quot;
    logic [DVD_W-1:0] dividend;
    logic             slot_free;

    logic [CW-1:0]    fxp_w;
    logic [CW-1:0]    lo_calc, hi_calc;
    logic             out_of_range;
    logic [CW-1:0]    half, f_raw, actual;
    logic [pfds_pkg::F_W-1:0] f_cl;
    logic             in_win;
    logic             at_min;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign freq_zero = (i_in_req.desired_freq_hz == '0);
    assign div_start = in_acc && !freq_zero;
    assign dividend  = DVD_W'(NUM) + DVD_W'(i_in_req.desired_freq_hz >> 1);
    assign slot_free = !r_ovld || !i_out_stall;

    pfds_div #(
        .DVD_W (DVD_W),
        .DSR_W (pfds_pkg::FREQ_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (i_in_req.desired_freq_hz),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // window, range check and search step arithmetic
    always_comb begin
        fxp_w   = CW'(r_fxp);
        lo_calc = ((fxp_w << 1) + fxp_w + CW'(2)) >> 2;
        hi_calc = ((fxp_w << 2) + fxp_w + CW'(2)) >> 2;
        out_of_range = (r_req.bit_count_min > r_req.bit_count_max) ||
                       (r_lo < (CW'(1) << r_req.bit_count_min)) ||
                       ((CW'(pfds_pkg::F_MAX) << r_req.bit_count_max) < r_hi);
        half  = (CW'(1) << r_pn) >> 1;
        f_raw = (fxp_w + half) >> r_pn;
        if (f_raw == '0) begin
            f_cl = pfds_pkg::F_W'(1);
        end else if (f_raw > CW'(pfds_pkg::F_MAX)) begin
            f_cl = pfds_pkg::F_W'(pfds_pkg::F_MAX);
        end else begin
            f_cl = f_raw[pfds_pkg::F_W-1:0];
        end
        actual = CW'(f_cl) << r_pn;
        in_win = (r_lo <= actual) && (actual <= r_hi);
        at_min = (r_pn == r_req.bit_count_min);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pfds_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = freq_zero ? pfds_pkg::ST_OUT : pfds_pkg::ST_DIV;
                end
            end
            pfds_pkg::ST_DIV: begin
                if (div_done) begin
                    n_state = pfds_pkg::ST_WIN;
                end
            end
            pfds_pkg::ST_WIN: begin
                n_state = pfds_pkg::ST_CHK;
            end
            pfds_pkg::ST_CHK: begin
                n_state = out_of_range ? pfds_pkg::ST_OUT : pfds_pkg::ST_SRCH;
            end
            pfds_pkg::ST_SRCH: begin
                if (in_win || at_min) begin
                    n_state = pfds_pkg::ST_OUT;
                end
            end
            pfds_pkg::ST_OUT: begin
                if (slot_free) begin
                    n_state = pfds_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pfds_pkg::ST_IDLE;
            end
        endcase
    end

    // result and bit count selection
    always_comb begin
        n_res = r_res;
        n_pn  = r_pn;
        case (r_state)
            pfds_pkg::ST_IDLE: begin
                n_res.status      = pfds_pkg::STS_FREQ_ZERO;
                n_res.bit_count   = '0;
                n_res.pre_divider = pfds_pkg::F_W'(1);
            end
            pfds_pkg::ST_CHK: begin
                n_pn = r_req.bit_count_max;
                n_res.status      = pfds_pkg::STS_RANGE;
                n_res.bit_count   = '0;
                n_res.pre_divider = pfds_pkg::F_W'(1);
            end
            pfds_pkg::ST_SRCH: begin
                n_res.bit_count   = r_pn;
                n_res.pre_divider = f_cl;
                if (in_win) begin
                    n_res.status = pfds_pkg::STS_OK;
                end else if (at_min) begin
                    n_res.status = pfds_pkg::STS_NO_FIT;
                end else begin
                    n_pn = r_pn - pfds_pkg::PN_W'(1);
                end
            end
            default: begin
                n_res = r_res;
                n_pn  = r_pn;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfds_pkg::ST_IDLE;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == pfds_pkg::ST_OUT && slot_free) begin
                r_ovld <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_pn  <= n_pn;
        if (in_acc) begin
            r_req <= i_in_req;
        end
        if (div_done) begin
            r_fxp <= div_quot[FXP_W-1:0];
        end
        if (r_state == pfds_pkg::ST_WIN) begin
            r_lo <= lo_calc;
            r_hi <= hi_calc;
        end
        if (r_state == pfds_pkg::ST_OUT && slot_free) begin
            r_rsp <= r_res;
        end
    end

    assign o_in_stall  = (r_state != pfds_pkg::ST_IDLE);
    assign o_out_valid = r_ovld;
    assign o_out_rsp   = r_rsp;

    a_err_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_rsp.status == pfds_pkg::STS_FREQ_ZERO ||
                         o_out_rsp.status == pfds_pkg::STS_RANGE)) |->
        (o_out_rsp.bit_count == '0 && o_out_rsp.pre_divider == pfds_pkg::F_W'(1)))
        else $error("error response carries nonzero fields");

    a_div_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == pfds_pkg::ST_DIV))
        else $error("divider finished outside divide state");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("block idle right after taking a request");

    a_prediv_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_rsp.pre_divider != '0))
        else $error("pre-divider of zero on output");

endmodule

@@ tb/pwm_freq_divider_search_tb.sv @@
// pwm_freq_divider_search_tb: self-checking bench for the pwm pre-divider and bit count search
// depends on pfds_pkg and pwm_freq_divider_search; predicts each response in place
// and compares it field by field against the output channel
`timescale 1ns / 100ps

module pwm_freq_divider_search_tb;

    localparam longint unsigned REF_HZ =
        longint'(pfds_pkg::REF_CLOCK_KHZ_DEF) * pfds_pkg::KHZ_TO_HZ;
    localparam int IDLE_PCT = 25;
    // covers the slowest search plus the output register
    localparam int SETTLE_CYCLES = 80;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    pfds_pkg::t_req i_in_req = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    pfds_pkg::t_rsp o_out_rsp;

    pfds_pkg::t_rsp divider_rsp_q[$];
    int   mismatches = 0;
    logic no_idle = 1'b0;

    pwm_freq_divider_search uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // target product and the +/-25 percent window around it
    function automatic void freq_window(input logic [pfds_pkg::FREQ_W-1:0] freq,
                                        output longint unsigned fxp,
                                        output longint unsigned lo,
                                        output longint unsigned hi);
        fxp = (REF_HZ + freq / 2) / freq;
        lo  = (fxp * 3 + 2) / 4;
        hi  = (fxp * 5 + 2) / 4;
    endfunction

    function automatic pfds_pkg::t_rsp search_divider(input pfds_pkg::t_req r);
        pfds_pkg::t_rsp rsp;
        longint unsigned fxp, lo, hi, f, actual;
        int pn;
        rsp.status      = pfds_pkg::STS_FREQ_ZERO;
        rsp.bit_count   = '0;
        rsp.pre_divider = 8'd1;
        if (r.desired_freq_hz == '0) begin
            return rsp;
        end
        freq_window(r.desired_freq_hz, fxp, lo, hi);
        if (r.bit_count_min > r.bit_count_max || lo < (64'd1 << r.bit_count_min) ||
            (64'(pfds_pkg::F_MAX) << r.bit_count_max) < hi) begin
            rsp.status = pfds_pkg::STS_RANGE;
            return rsp;
        end
        f = 1;
        for (pn = int'(r.bit_count_max); pn >= int'(r.bit_count_min); pn--) begin
            f = (fxp + ((64'd1 << pn) >> 1)) >> pn;
            if (f < 1) begin
                f = 1;
            end
            if (f > pfds_pkg::F_MAX) begin
                f = pfds_pkg::F_MAX;
            end
            actual = f << pn;
            if (lo <= actual && actual <= hi) begin
                rsp.status      = pfds_pkg::STS_OK;
                rsp.bit_count   = pfds_pkg::PN_W'(pn);
                rsp.pre_divider = pfds_pkg::F_W'(f);
                return rsp;
            end
        end
        // f still holds the value tried at the minimum bit count
        rsp.status      = pfds_pkg::STS_NO_FIT;
        rsp.bit_count   = r.bit_count_min;
        rsp.pre_divider = pfds_pkg::F_W'(f);
        return rsp;
    endfunction

    function automatic pfds_pkg::t_req make_req(input logic [pfds_pkg::FREQ_W-1:0] freq,
                                                input logic [pfds_pkg::PN_W-1:0] pn_min,
                                                input logic [pfds_pkg::PN_W-1:0] pn_max);
        pfds_pkg::t_req r;
        r.desired_freq_hz = freq;
        r.bit_count_min   = pn_min;
        r.bit_count_max   = pn_max;
        return r;
    endfunction

    function automatic pfds_pkg::t_req noise_req();
        logic [pfds_pkg::FREQ_W-1:0] freq;
        freq = pfds_pkg::FREQ_W'($urandom);
        if ($urandom_range(0, 99) < 4) begin
            freq = '0;
        end
        return make_req(freq, pfds_pkg::PN_W'($urandom), pfds_pkg::PN_W'($urandom));
    endfunction

    // bit counts chosen so the range check passes and the search runs;
    // pinch forces min == max when the bounds allow it, which is where no-fit shows up
    function automatic pfds_pkg::t_req fitting_req(input logic pinch);
        logic [pfds_pkg::FREQ_W-1:0] freq;
        longint unsigned fxp, lo, hi;
        int shift, lo_log, need, pn_min, pn_max;
        shift = $urandom_range(0, pfds_pkg::FREQ_W - 1);
        freq = pfds_pkg::FREQ_W'((1 << shift) | ($urandom & ((1 << shift) - 1)));
        freq_window(freq, fxp, lo, hi);
        lo_log = 0;
        while (lo_log < 31 && (64'd2 << lo_log) <= lo) begin
            lo_log++;
        end
        need = 0;
        while ((64'(pfds_pkg::F_MAX) << need) < hi) begin
            need++;
        end
        if (pinch && need <= lo_log) begin
            pn_min = $urandom_range(need, lo_log);
            pn_max = pn_min;
        end else begin
            pn_min = $urandom_range(0, lo_log);
            pn_max = $urandom_range((need > pn_min) ? need : pn_min, 31);
        end
        return make_req(freq, pfds_pkg::PN_W'(pn_min), pfds_pkg::PN_W'(pn_max));
    endfunction

    task automatic send_req(input pfds_pkg::t_req r);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        divider_rsp_q.push_back(search_divider(r));
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (divider_rsp_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic test_directed();
        send_req(make_req(20'd0, 5'd0, 5'd31));
        send_req(make_req(20'd0, 5'd31, 5'd0));
        send_req(make_req(20'd1, 5'd0, 5'd31));
        send_req(make_req(20'hFFFFF, 5'd0, 5'd31));
        send_req(make_req(20'hFFFFF, 5'd31, 5'd31));
        send_req(make_req(20'd1, 5'd0, 5'd0));
        send_req(make_req(20'd1000, 5'd5, 5'd4));
        send_req(make_req(20'd1000, 5'd31, 5'd0));
        send_req(make_req(20'd1000, 5'd0, 5'd31));
        // window falls between two powers of two: no bit count fits
        send_req(make_req(20'd1177, 5'd14, 5'd14));
        send_req(make_req(20'd1177, 5'd13, 5'd14));
        send_req(make_req(20'h55555, 5'd0, 5'd31));
        send_req(make_req(20'hAAAAA, 5'd1, 5'd30));
        send_req(make_req(20'h80000, 5'd2, 5'd2));
        send_req(make_req(20'd200, 5'd10, 5'd10));
        send_req(make_req(20'd105883, 5'd0, 5'd0));
        send_req(make_req(20'd105882, 5'd0, 5'd0));
        send_req(make_req(20'd25000, 5'd0, 5'd21));
    endtask

    task automatic test_noise(input int count);
        repeat (count) send_req(noise_req());
    endtask

    task automatic test_search(input int count);
        repeat (count / 2) send_req(fitting_req(1'b0));
        // let everything in flight come out before going on
        wait_drain();
        repeat (count - count / 2) send_req(fitting_req(1'b0));
    endtask

    task automatic test_back_to_back(input int count);
        no_idle = 1'b1;
        repeat (count) begin
            if ($urandom_range(0, 99) < 70) begin
                send_req(fitting_req($urandom_range(0, 3) == 0));
            end else begin
                send_req(noise_req());
            end
        end
        no_idle = 1'b0;
    endtask

    task automatic test_no_fit(input int count);
        repeat (count) send_req(fitting_req(1'b1));
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= no_idle ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);
    end

    always @(posedge i_clk) begin
        pfds_pkg::t_rsp exp_rsp;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (divider_rsp_q.size() == 0) begin
                $display("%0t: unexpected response status=%0d bit_count=%0d pre_divider=%0d",
                         $time, o_out_rsp.status, o_out_rsp.bit_count,
                         o_out_rsp.pre_divider);
                mismatches++;
            end else begin
                exp_rsp = divider_rsp_q.pop_front();
                if (o_out_rsp.status !== exp_rsp.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_rsp.status, o_out_rsp.status);
                    mismatches++;
                end
                if (o_out_rsp.bit_count !== exp_rsp.bit_count) begin
                    $display("%0t: bit_count expected %0d actual %0d",
                             $time, exp_rsp.bit_count, o_out_rsp.bit_count);
                    mismatches++;
                end
                if (o_out_rsp.pre_divider !== exp_rsp.pre_divider) begin
                    $display("%0t: pre_divider expected %0d actual %0d",
                             $time, exp_rsp.pre_divider, o_out_rsp.pre_divider);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_noise(400);
        test_search(500);
        test_back_to_back(250);
        test_no_fit(180);
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
